FILE: rtl/md5bc_pkg.sv
// md5bc_pkg: shared constants, types and step tables of the md5 block compressor
`timescale 1ns / 1ps
`default_nettype none

package md5bc_pkg;

    localparam int WORD_W      = 32;
    localparam int BLK_WORDS   = 16;
    localparam int WIDX_W      = 4;
    localparam int NUM_STEPS   = 64;
    localparam int STEP_W      = 6;
    localparam int ROT_W       = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int DIGEST_W    = 4 * WORD_W;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_INIT_A = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INIT_B = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INIT_C = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INIT_D = 2'd3;

    // standard initial chaining value
    localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
    localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
    localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
    localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

    // round function groups
    localparam logic [1:0] GRP_F = 2'd0;
    localparam logic [1:0] GRP_G = 2'd1;
    localparam logic [1:0] GRP_H = 2'd2;
    localparam logic [1:0] GRP_I = 2'd3;

    // control bundle from the sequencer to the datapath
    typedef struct packed {
        logic              wr_en;
        logic [WIDX_W-1:0] wr_addr;
        logic [WIDX_W-1:0] rd_addr;
        logic              load_cv;
        logic              load_work;
        logic              step_en;
        logic [STEP_W-1:0] step;
        logic              finish;
    } md5bc_ctrl_t;

    // additive constant of each step
    function automatic logic [WORD_W-1:0] step_const(input logic [STEP_W-1:0] idx);
        logic [WORD_W-1:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = '0;
        endcase
        return k;
    endfunction

    // left rotation amount of each step
    function automatic logic [ROT_W-1:0] rot_amount(input logic [STEP_W-1:0] idx);
        logic [ROT_W-1:0] s;
        case ({idx[5:4], idx[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
            default: s = '0;
        endcase
        return s;
    endfunction

    // message word used by each step
    function automatic logic [WIDX_W-1:0] msg_index(input logic [STEP_W-1:0] idx);
        logic [WIDX_W-1:0] lo;
        logic [WIDX_W-1:0] g;
        lo = idx[WIDX_W-1:0];
        case (idx[5:4])
            GRP_F:   g = lo;
            GRP_G:   g = WIDX_W'(lo * 4'd5 + 4'd1);
            GRP_H:   g = WIDX_W'(lo * 4'd3 + 4'd5);
            GRP_I:   g = WIDX_W'(lo * 4'd7);
            default: g = lo;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/md5bc_ram.sv
// md5bc_ram: generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module md5bc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/md5bc_round.sv
// md5bc_round: one md5 step, shared over all 64 steps of a block
`timescale 1ns / 1ps
`default_nettype none

module md5bc_round
    import md5bc_pkg::*;
(
    input  wire logic [STEP_W-1:0] step,
    input  wire logic [WORD_W-1:0] a_in,
    input  wire logic [WORD_W-1:0] b_in,
    input  wire logic [WORD_W-1:0] c_in,
    input  wire logic [WORD_W-1:0] d_in,
    input  wire logic [WORD_W-1:0] msg,
    output logic      [WORD_W-1:0] a_out,
    output logic      [WORD_W-1:0] b_out,
    output logic      [WORD_W-1:0] c_out,
    output logic      [WORD_W-1:0] d_out
);

    logic [WORD_W-1:0]   f;
    logic [WORD_W-1:0]   t;
    logic [2*WORD_W-1:0] dbl;

    always_comb begin
        case (step[5:4])
            GRP_F:   f = (b_in & c_in) | (~b_in & d_in);
            GRP_G:   f = (b_in & d_in) | (c_in & ~d_in);
            GRP_H:   f = b_in ^ c_in ^ d_in;
            GRP_I:   f = c_in ^ (b_in | ~d_in);
            default: f = '0;
        endcase
        t   = a_in + f + msg + step_const(step);
        // rotate left: upper half of the doubled word shifted up
        dbl = {t, t} << rot_amount(step);
        a_out = d_in;
        b_out = b_in + dbl[2*WORD_W-1:WORD_W];
        c_out = b_in;
        d_out = c_in;
    end

endmodule

`default_nettype wire

FILE: rtl/md5bc_seq.sv
// md5bc_seq: sequencer for word loading, 64 shared-unit steps and the final fold
`timescale 1ns / 1ps
`default_nettype none

module md5bc_seq
    import md5bc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    input  wire logic  new_message,
    input  wire logic  out_free,
    output logic       s_tready,
    output md5bc_ctrl_t ctrl
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_PREP  = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;
    localparam logic [1:0] ST_FINAL = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [WIDX_W-1:0] word_cnt_reg, word_cnt_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [WIDX_W-1:0] slot;

    always_comb begin
        state_next    = state_reg;
        word_cnt_next = word_cnt_reg;
        step_next     = step_reg;
        ctrl          = '0;
        s_tready      = (state_reg == ST_LOAD);
        // a new message restarts the block at word zero
        slot          = new_message ? '0 : word_cnt_reg;
        ctrl.wr_addr  = slot;
        ctrl.rd_addr  = msg_index('0);
        ctrl.step     = step_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    ctrl.wr_en    = 1'b1;
                    ctrl.load_cv  = new_message;
                    word_cnt_next = slot + 4'd1;
                    if (slot == WIDX_W'(BLK_WORDS - 1)) begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                ctrl.load_work = 1'b1;
                step_next      = '0;
                state_next     = ST_ROUND;
            end
            ST_ROUND: begin
                ctrl.step_en = 1'b1;
                // fetch the word of the following step
                ctrl.rd_addr = msg_index(step_reg + 6'd1);
                step_next    = step_reg + 6'd1;
                if (step_reg == STEP_W'(NUM_STEPS - 1)) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    ctrl.finish = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            word_cnt_reg <= '0;
            step_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            word_cnt_reg <= word_cnt_next;
            step_reg     <= step_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/md5_block_compress.sv
// md5_block_compress: md5 compression over a stream of padded 32-bit message words
//
//   channel   dir  handshake           payload
//   --------  ---  ------------------  ------------------------------------------
//   s_        in   s_tvalid/s_tready   s_tdata message_word, s_tuser new_message
//   m_        out  m_tvalid/m_tready   m_tdata digest_a..digest_d (a lowest)
//   cfg_      in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// words are taken one per cycle while the input is ready; after the sixteenth word
// of a block the input stays not ready through one read-ahead of the word ram,
// the 64 steps through the single shared round unit, and one fold into the
// chaining value.
// the fold waits while an earlier digest still sits unread in the output register.
// reset loads the standard initial value into the init registers and the chaining
// value; the word count restarts at zero.
`timescale 1ns / 1ps
`default_nettype none

module md5_block_compress
    import md5bc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input words
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [WORD_W-1:0]      s_tdata,    // [31:0] message_word
    input  wire logic [0:0]             s_tuser,    // [0] new_message
    // digest results
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [DIGEST_W-1:0]    m_tdata,    // [31:0] a, [63:32] b, [95:64] c, [127:96] d
    // init register writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]      cfg_data
);

    md5bc_ctrl_t ctrl;

    // init registers
    logic [WORD_W-1:0] init_a_reg, init_b_reg, init_c_reg, init_d_reg;
    // chaining value
    logic [WORD_W-1:0] cv_a_reg, cv_b_reg, cv_c_reg, cv_d_reg;
    logic [WORD_W-1:0] cv_a_next, cv_b_next, cv_c_next, cv_d_next;
    // working variables of the step loop
    logic [WORD_W-1:0] wa_reg, wb_reg, wc_reg, wd_reg;
    logic [WORD_W-1:0] wa_next, wb_next, wc_next, wd_next;
    // output register
    logic                m_tvalid_reg;
    logic [DIGEST_W-1:0] m_tdata_reg;

    logic              out_free;
    logic [WORD_W-1:0] msg_word;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    md5bc_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .new_message (s_tuser[0]),
        .out_free    (out_free),
        .s_tready    (s_tready),
        .ctrl        (ctrl)
    );

    // block words, read one step ahead
    md5bc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BLK_WORDS)
    ) u_words (
        .aclk    (aclk),
        .wr_en   (ctrl.wr_en),
        .wr_addr (ctrl.wr_addr),
        .wr_data (s_tdata),
        .rd_addr (ctrl.rd_addr),
        .rd_data (msg_word)
    );

    md5bc_round u_round (
        .step  (ctrl.step),
        .a_in  (wa_reg),
        .b_in  (wb_reg),
        .c_in  (wc_reg),
        .d_in  (wd_reg),
        .msg   (msg_word),
        .a_out (wa_next),
        .b_out (wb_next),
        .c_out (wc_next),
        .d_out (wd_next)
    );

    // fold of the step result into the chaining value
    assign cv_a_next = cv_a_reg + wa_reg;
    assign cv_b_next = cv_b_reg + wb_reg;
    assign cv_c_next = cv_c_reg + wc_reg;
    assign cv_d_next = cv_d_reg + wd_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_a_reg <= IV_A;
            init_b_reg <= IV_B;
            init_c_reg <= IV_C;
            init_d_reg <= IV_D;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_INIT_A: init_a_reg <= cfg_data;
                REG_INIT_B: init_b_reg <= cfg_data;
                REG_INIT_C: init_c_reg <= cfg_data;
                REG_INIT_D: init_d_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // chaining value: reload on a new message, accumulate at the fold
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_a_reg <= IV_A;
            cv_b_reg <= IV_B;
            cv_c_reg <= IV_C;
            cv_d_reg <= IV_D;
        end else if (ctrl.load_cv) begin
            cv_a_reg <= init_a_reg;
            cv_b_reg <= init_b_reg;
            cv_c_reg <= init_c_reg;
            cv_d_reg <= init_d_reg;
        end else if (ctrl.finish) begin
            cv_a_reg <= cv_a_next;
            cv_b_reg <= cv_b_next;
            cv_c_reg <= cv_c_next;
            cv_d_reg <= cv_d_next;
        end
    end

    // working variables: seeded from the chaining value, one step per cycle
    always_ff @(posedge aclk) begin
        if (ctrl.load_work) begin
            wa_reg <= cv_a_reg;
            wb_reg <= cv_b_reg;
            wc_reg <= cv_c_reg;
            wd_reg <= cv_d_reg;
        end else if (ctrl.step_en) begin
            wa_reg <= wa_next;
            wb_reg <= wb_next;
            wc_reg <= wc_next;
            wd_reg <= wd_next;
        end
    end

    // result register, freed by the downstream request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.finish) begin
            m_tdata_reg <= {cv_d_next, cv_c_next, cv_b_next, cv_a_next};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/md5bc_check.sv
// md5bc_check: port-level checks of the md5 block compressor, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module md5bc_check
    import md5bc_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic [0:0]             s_tuser,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [DIGEST_W-1:0]    m_tdata
);

    logic [WIDX_W-1:0] seen_reg;
    logic [WIDX_W-1:0] seen_slot;
    logic              s_acc;

    assign s_acc     = s_tvalid && s_tready;
    assign seen_slot = s_tuser[0] ? '0 : seen_reg;

    // words seen in the current block, from the port side
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else if (s_acc) begin
            seen_reg <= seen_slot + 4'd1;
        end
    end

    // last word of a block stops further input while the steps run
    a_block_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (seen_slot == WIDX_W'(BLK_WORDS - 1)) |=> !s_tready)
        else $error("input ready right after the last word of a block");

    // a digest appears only after the block work kept the input closed
    a_digest_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready) && (seen_reg == '0))
        else $error("digest appeared without a completed block");

    // a pending digest holds until taken
    a_digest_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("pending digest changed or dropped");

    // no result straight out of reset, and the input ready
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind md5_block_compress md5bc_check u_check (.*);

`default_nettype wire

FILE: bench/md5_block_checker.sv
// md5_block_checker: watches the md5 block compressor channels, predicts each digest and compares
`timescale 1ns / 1ps

module md5_block_checker
    import md5bc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [WORD_W-1:0]      s_tdata,
    input  wire logic [0:0]             s_tuser,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [DIGEST_W-1:0]    m_tdata,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]      cfg_data,
    output int                          fail_count,
    output int                          digests_pending
);

    // a in the lowest bits, as on m_tdata
    typedef struct packed {
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] a;
    } digest_t;

    // rotation per group and step position, group 0 position 0 lowest
    localparam logic [16*ROT_W-1:0] SHIFT_TBL = {
        5'd21, 5'd15, 5'd10, 5'd6,
        5'd23, 5'd16, 5'd11, 5'd4,
        5'd20, 5'd14, 5'd9,  5'd5,
        5'd22, 5'd17, 5'd12, 5'd7
    };

    logic [WORD_W-1:0] step_k   [0:NUM_STEPS-1];
    logic [WORD_W-1:0] init_word[0:3];
    logic [WORD_W-1:0] chain    [0:3];
    logic [WORD_W-1:0] msg_buf  [0:BLK_WORDS-1];
    logic [WIDX_W-1:0] word_idx;
    digest_t           digest_q[$];

    // additive constants from the integer part of |sin(i+1)| * 2^32
    initial begin : fill_consts
        real         r;
        logic [63:0] kv;
        for (int i = 0; i < NUM_STEPS; i++) begin
            r = $sin(i + 1.0);
            if (r < 0.0) r = -r;
            kv = $floor(r * 4294967296.0);
            step_k[i] = kv[WORD_W-1:0];
        end
    end

    function automatic digest_t fold_block();
        logic [WORD_W-1:0] wa, wb, wc, wd, mix, sum;
        logic [63:0]       spun;
        logic [WIDX_W-1:0] sel;
        logic [STEP_W-1:0] st;
        logic [ROT_W-1:0]  sh;
        digest_t           nxt;
        wa = chain[0];
        wb = chain[1];
        wc = chain[2];
        wd = chain[3];
        for (int i = 0; i < NUM_STEPS; i++) begin
            st = STEP_W'(i);
            case (st[5:4])
                GRP_F: begin
                    mix = (wb & wc) | (~wb & wd);
                    sel = st[3:0];
                end
                GRP_G: begin
                    mix = (wb & wd) | (wc & ~wd);
                    sel = WIDX_W'(st[3:0] * 5 + 1);
                end
                GRP_H: begin
                    mix = wb ^ wc ^ wd;
                    sel = WIDX_W'(st[3:0] * 3 + 5);
                end
                default: begin
                    mix = wc ^ (wb | ~wd);
                    sel = WIDX_W'(st[3:0] * 7);
                end
            endcase
            sum  = wa + mix + msg_buf[sel] + step_k[st];
            sh   = SHIFT_TBL[{st[5:4], st[1:0]} * ROT_W +: ROT_W];
            spun = {sum, sum} << sh;
            wa = wd;
            wd = wc;
            wc = wb;
            wb = wb + spun[63:32];
        end
        nxt.a = chain[0] + wa;
        nxt.b = chain[1] + wb;
        nxt.c = chain[2] + wc;
        nxt.d = chain[3] + wd;
        return nxt;
    endfunction

    always @(posedge aclk) begin
        digest_t want;
        digest_t got;
        if (!aresetn) begin
            init_word[0] = IV_A;
            init_word[1] = IV_B;
            init_word[2] = IV_C;
            init_word[3] = IV_D;
            for (int i = 0; i < 4; i++) chain[i] = init_word[i];
            word_idx = '0;
            digest_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_INIT_A: init_word[0] = cfg_data;
                    REG_INIT_B: init_word[1] = cfg_data;
                    REG_INIT_C: init_word[2] = cfg_data;
                    REG_INIT_D: init_word[3] = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (digest_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("digest %h with no block pending", got);
                end else begin
                    want = digest_q.pop_front();
                    if (got.a !== want.a || got.b !== want.b ||
                        got.c !== want.c || got.d !== want.d) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("digest mismatch: exp a=%h b=%h c=%h d=%h, got a=%h b=%h c=%h d=%h",
                                     want.a, want.b, want.c, want.d,
                                     got.a, got.b, got.c, got.d);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                // new message drops any partial block and restarts the chain
                if (s_tuser[0]) begin
                    for (int i = 0; i < 4; i++) chain[i] = init_word[i];
                    word_idx = '0;
                end
                msg_buf[word_idx] = s_tdata;
                word_idx = word_idx + 1'b1;
                if (word_idx == '0) begin
                    want = fold_block();
                    chain[0] = want.a;
                    chain[1] = want.b;
                    chain[2] = want.c;
                    chain[3] = want.d;
                    digest_q.push_back(want);
                end
            end
        end
        digests_pending = digest_q.size();
    end

endmodule

FILE: bench/testbench.sv
// testbench: stimulus, flow control and verdict for the md5 block compressor
`timescale 1ns / 1ps

module testbench;
    import md5bc_pkg::*;

    // generous cycle budget, far above the slowest correct run
    localparam int CYCLE_LIMIT  = 200000;
    // room for the read-ahead, the 64 steps and the fold, plus margin
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_WORDS  = 100;
    localparam int NUM_PHASES   = 5;
    localparam int LONG_HOLD    = 600;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [WORD_W-1:0]      s_tdata;     // [31:0] message_word
    logic [0:0]             s_tuser;     // [0] new_message
    logic                   m_tvalid;
    logic                   m_tready;
    logic [DIGEST_W-1:0]    m_tdata;     // [31:0] a, [63:32] b, [95:64] c, [127:96] d
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [WORD_W-1:0]      cfg_data;

    int fail_count;
    int digests_pending;
    int cycle_count;

    // flow control knobs for the sender and the receiver
    bit tx_idle;
    bit rx_idle;
    int hold_asks;

    md5_block_compress u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    md5_block_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .digests_pending (digests_pending)
    );

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog: a hang or a lost digest ends here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // receiver: random stall bursts, and a long hold-off on request
    initial begin : receiver
        int hold_seen;
        int hold_left;
        int stall_left;
        hold_seen  = 0;
        hold_left  = 0;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (rx_idle && $urandom_range(0, 7) == 0) begin
                // a stall burst begins with this one
                stall_left = $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // mostly random words, with the all-zero and all-one words now and then
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // one word request, preceded by an optional idle burst
    task automatic push_word(input logic [WORD_W-1:0] word, input bit fresh);
        int gap;
        gap = (tx_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid   <= 1'b1;
        s_tdata    <= word;
        s_tuser[0] <= fresh;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic stop_words();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // every digest back, then room for a block still in the round unit
    task automatic wait_drained();
        while (digests_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // a message of one to three whole blocks, or now and then a cut-off partial block
    task automatic send_message(input bit fresh, inout int sent);
        int n;
        if ($urandom_range(0, 7) == 0) n = $urandom_range(1, BLK_WORDS - 1);
        else n = BLK_WORDS * $urandom_range(1, 3);
        for (int k = 0; k < n; k++) push_word(rand_word(), fresh && k == 0);
        sent += n;
    endtask

    initial begin : stimulus
        logic [WORD_W-1:0] iv [0:3];
        logic [WORD_W-1:0] w;
        int                sent;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_INIT_A;
        cfg_data   = '0;
        tx_idle    = 1'b1;
        rx_idle    = 1'b1;
        hold_asks  = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // first block after reset, no new-message flag: runs on the reset init values;
        // words at the extremes and alternating bit patterns
        for (int k = 0; k < BLK_WORDS; k++) begin
            case (k)
                0:       w = '0;
                1:       w = '1;
                2:       w = 32'h0000_0001;
                3:       w = 32'h8000_0000;
                4:       w = 32'haaaa_aaaa;
                5:       w = 32'h5555_5555;
                default: w = $urandom();
            endcase
            push_word(w, 1'b0);
        end
        // partial block cut short by a new message in mid-block
        for (int k = 0; k < 3; k++) push_word($urandom(), 1'b0);
        push_word('1, 1'b1);
        for (int k = 0; k < 4; k++) push_word(rand_word(), 1'b0);
        stop_words();
        wait_drained();

        // phases of init settings: zeros, ones, random, standard, random
        for (int p = 0; p < NUM_PHASES; p++) begin
            for (int i = 0; i < 4; i++) begin
                case (p)
                    0:       iv[i] = '0;
                    1:       iv[i] = '1;
                    3:       iv[i] = (i == 0) ? IV_A : (i == 1) ? IV_B : (i == 2) ? IV_C : IV_D;
                    default: iv[i] = $urandom();
                endcase
            end
            write_reg(REG_INIT_A, iv[0]);
            write_reg(REG_INIT_B, iv[1]);
            write_reg(REG_INIT_C, iv[2]);
            write_reg(REG_INIT_D, iv[3]);

            // no idling at all in the last phase
            if (p == NUM_PHASES - 1) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            // long receiver hold-off while words keep coming: input backs up
            if (p == 1) hold_asks++;

            // even phases open without the flag, so the new init values wait
            sent = 0;
            send_message(p[0], sent);
            while (sent < PHASE_WORDS)
                send_message($urandom_range(0, 9) != 0, sent);
            stop_words();
            wait_drained();
        end

        if (fail_count == 0 && digests_pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
